// ----- rtl/spv_pkg.sv -----
// Shared constants, types and byte classifiers for the safe path validator.
package spv_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_CTL   = 8'h1f;
	localparam logic [7:0] CH_DEL   = 8'h7f;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_TILDE = 8'h7e;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_LT    = 8'h3c;
	localparam logic [7:0] CH_GT    = 8'h3e;
	localparam logic [7:0] CH_PIPE  = 8'h7c;
	localparam logic [7:0] CH_COLON = 8'h3a;

	localparam logic [1:0] POS_FIRST  = 2'd0;
	localparam logic [1:0] POS_SECOND = 2'd1;
	localparam logic [1:0] POS_LATER  = 2'd2;

	localparam int TDATA_W = 8;

	typedef struct packed {
		logic term;
		logic safe;
	} verdict_t;

	function automatic logic is_lead_bad(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_DOT) || (c == CH_TILDE) || (c == CH_SLASH);
	endfunction

	function automatic logic is_forbidden(input logic [7:0] c);
		return (c <= CH_CTL) || (c == CH_DEL) || (c == CH_BSL) || (c == CH_LT) ||
			(c == CH_GT) || (c == CH_PIPE);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
	endfunction

endpackage

// ----- rtl/spv_rules.sv -----
// Path rule state and the verdict logic applied to one byte.
module spv_rules (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [7:0]        path_byte,
	output spv_pkg::verdict_t verdict
);
	import spv_pkg::*;

	logic [1:0]  pos_q;
	logic [7:0]  first_q;
	logic [23:0] recent_q;
	logic        rej_q;
	logic        slash_q;
	logic        segbad_q;

	logic [7:0] p1, p2, p3;
	logic       term;
	logic       bad_end;
	logic       rej_next;

	assign p1   = recent_q[7:0];
	assign p2   = recent_q[15:8];
	assign p3   = recent_q[23:16];
	assign term = (path_byte == CH_NUL);

	always_comb begin
		bad_end = rej_q || (pos_q == POS_FIRST) || (slash_q && segbad_q) ||
			(p1 == CH_SPACE) || (p1 == CH_SLASH) ||
			((p2 == CH_SLASH) && (p1 == CH_DOT)) ||
			((p3 == CH_SLASH) && (p2 == CH_DOT) && (p1 == CH_DOT));
		rej_next = rej_q || is_forbidden(path_byte);
		if (pos_q == POS_FIRST && is_lead_bad(path_byte))
			rej_next = 1'b1;
		if (pos_q == POS_SECOND && is_letter(first_q) && path_byte == CH_COLON)
			rej_next = 1'b1;
		if (path_byte == CH_SLASH) begin
			if ((p2 == CH_SLASH) && (p1 == CH_DOT))
				rej_next = 1'b1;
			if ((p3 == CH_SLASH) && (p2 == CH_DOT) && (p1 == CH_DOT))
				rej_next = 1'b1;
		end
	end

	assign verdict.term = term;
	assign verdict.safe = !bad_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_FIRST;
			first_q  <= '0;
			recent_q <= '0;
			rej_q    <= 1'b0;
			slash_q  <= 1'b0;
			segbad_q <= 1'b0;
		end else if (en) begin
			if (term) begin
				// clear everything once the verdict is out
				pos_q    <= POS_FIRST;
				first_q  <= '0;
				recent_q <= '0;
				rej_q    <= 1'b0;
				slash_q  <= 1'b0;
				segbad_q <= 1'b0;
			end else begin
				rej_q <= rej_next;
				if (pos_q == POS_FIRST)
					first_q <= path_byte;
				if (pos_q != POS_FIRST && p1 == CH_SLASH)
					segbad_q <= is_lead_bad(path_byte);
				if (path_byte == CH_SLASH)
					slash_q <= 1'b1;
				if (pos_q != POS_LATER)
					pos_q <= pos_q + 2'd1;
				recent_q <= {recent_q[15:0], path_byte};
			end
		end
	end

endmodule

// ----- rtl/safe_path_validator_core.sv -----
// Top level: input register, path rule stage and output register of the validator.
//
//  channel | direction | tdata (low bit up)        | transaction
//  s_axis  | in        | path_byte[7:0]            | one path byte, zero ends path
//  m_axis  | out       | path_is_safe[0], zeros    | one verdict per zero byte
//
// One byte per cycle while no verdict stalls; each byte passes through the input register,
// and a zero byte loads its verdict into the output register as it leaves.
// The rule flags and the last three bytes update together from the input register.
// Reset clears the flags and both valid bits at once; no clearing pass.
// A stalled verdict holds only zero bytes in the input register; other bytes keep flowing.
module safe_path_validator_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [spv_pkg::TDATA_W-1:0] s_tdata,  // [7:0] path_byte
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [spv_pkg::TDATA_W-1:0] m_tdata   // [0] path_is_safe, [7:1] zero
);
	import spv_pkg::*;

	logic       byte_valid_s1;
	logic [7:0] byte_s1;
	logic       adv_s1;
	logic       out_valid_q;
	logic       out_safe_q;
	verdict_t   verdict;

	spv_rules u_rules (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv_s1),
		.path_byte (byte_s1),
		.verdict   (verdict)
	);

	// a plain byte always moves on; a terminator needs the output slot
	assign adv_s1   = byte_valid_s1 && (!verdict.term || !out_valid_q || m_tready);
	assign s_tready = !byte_valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (s_tready)
				byte_valid_s1 <= s_tvalid;
			if (adv_s1 && verdict.term)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			byte_s1 <= s_tdata;
		if (adv_s1 && verdict.term)
			out_safe_q <= verdict.safe;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TDATA_W-1){1'b0}}, out_safe_q};

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tvalid && s_tready && byte_valid_s1 && !adv_s1))
		else $error("input register overwritten while held");

	a_verdict_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && verdict.term) |=> out_valid_q)
		else $error("terminator did not produce a verdict");

	a_verdict_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && m_tready && !(adv_s1 && verdict.term)) |=> !out_valid_q)
		else $error("verdict repeated after it was taken");

	a_no_lost_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !(adv_s1 && verdict.term))
		else $error("verdict replaced before it was taken");

endmodule
